// ===== sv/sfu_pkg.sv =====
package sfu_pkg;

  typedef struct packed {
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic signed [31:0] particle_z;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic signed [31:0] other_z;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               saturated;
  } result_t;

  localparam int AD_W   = 33;
  localparam int SQ_W   = 66;
  localparam int LEN_W  = 33;
  localparam int SC_W   = 64;
  localparam int NUM_W  = 97;
  localparam int Q_W    = 32;

  localparam logic CFG_REST   = 1'b0;
  localparam logic CFG_SPRING = 1'b1;

  // per-item lane data that rides along the pipeline
  typedef struct packed {
    logic [2:0][AD_W-1:0] ad;
    logic [2:0]           dpos;
  } lane_t;

endpackage

// ===== sv/spring_force_unit.sv =====
// Spring force unit: takes a particle position and the spring's other end
// (signed fixed point, FRAC_BITS fraction bits) and returns the 3D spring
// force on the particle, -d * |len(d) - rest_length| * spring_constant /
// len(d), each component clamped to 32 bits with a saturated flag; coincident
// ends give a zero force. One item is taken every cycle unless the output
// stalls; each passes a bit-per-stage square root of 33 stages and a
// bit-per-stage divider of 32 stages, three lanes wide. While the output is
// stalled the whole pipeline holds, so the input stalls too. Registers must be
// written only while the pipeline is empty; the block does not enforce this.
module spring_force_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pair_valid,
  output logic            pair_stall,
  input  sfu_pkg::pair_t  pair,
  output logic            result_valid,
  input  logic            result_stall,
  output sfu_pkg::result_t result,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [30:0]     cfg_data
);

  localparam int AD_W  = sfu_pkg::AD_W;
  localparam int SQ_W  = sfu_pkg::SQ_W;
  localparam int LEN_W = sfu_pkg::LEN_W;
  localparam int SC_W  = sfu_pkg::SC_W;
  localparam int NUM_W = sfu_pkg::NUM_W;
  localparam int Q_W   = sfu_pkg::Q_W;
  localparam int RT_W  = SQ_W + 1;
  localparam int SQRT_STEPS = LEN_W;
  localparam int DIV_STEPS  = Q_W;

  logic [30:0] rest_length;
  logic [30:0] spring_constant;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length     <= 31'd65536;
      spring_constant <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfu_pkg::CFG_REST:   rest_length     <= cfg_data;
        sfu_pkg::CFG_SPRING: spring_constant <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv        = !(result_valid && result_stall);
  assign pair_stall = !adv;

  // stage 1: differences and magnitudes
  logic signed [32:0] dif [3];
  sfu_pkg::lane_t     lane_in;

  always_comb begin
    dif[0] = {pair.particle_x[31], pair.particle_x} - {pair.other_x[31], pair.other_x};
    dif[1] = {pair.particle_y[31], pair.particle_y} - {pair.other_y[31], pair.other_y};
    dif[2] = {pair.particle_z[31], pair.particle_z} - {pair.other_z[31], pair.other_z};
    for (int i = 0; i < 3; i++) begin
      lane_in.ad[i]   = dif[i][32] ? AD_W'(-dif[i]) : AD_W'(dif[i]);
      lane_in.dpos[i] = !dif[i][32] && (dif[i] != '0);
    end
  end

  logic           v1, v2;
  sfu_pkg::lane_t c1, c2;
  logic [SQ_W-1:0] sq [3];

  // square root pipeline, index 0 loaded by the sum stage
  logic            sv    [0:SQRT_STEPS];
  sfu_pkg::lane_t  sc    [0:SQRT_STEPS];
  logic [RT_W-1:0] srem  [0:SQRT_STEPS];
  logic [LEN_W-1:0] sroot [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      sv[0] <= 1'b0;
    end else if (adv) begin
      v1    <= pair_valid;
      v2    <= v1;
      sv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= lane_in;
      c2 <= c1;
      for (int i = 0; i < 3; i++) sq[i] <= c1.ad[i] * c1.ad[i];
      sc[0]    <= c2;
      srem[0]  <= RT_W'(sq[0]) + RT_W'(sq[1]) + RT_W'(sq[2]);
      sroot[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int B = SQRT_STEPS - 1 - k;
    logic [RT_W-1:0] trial;
    // root holds only bits above B, so the shifted root and the new square term
    // do not overlap
    assign trial = (RT_W'(sroot[k]) << (B + 1)) | (RT_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (adv) sv[k+1] <= sv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sc[k+1] <= sc[k];
        if (trial <= srem[k]) begin
          srem[k+1]  <= srem[k] - trial;
          sroot[k+1] <= sroot[k] | (LEN_W'(1) << B);
        end else begin
          srem[k+1]  <= srem[k];
          sroot[k+1] <= sroot[k];
        end
      end
    end
  end

  // extension, scale, partial products, numerator
  logic                 ve, vm, vp, vn;
  sfu_pkg::lane_t       ce, cm, cp, cn;
  logic [LEN_W-1:0]     le, lm, lp, ln;
  logic                 ze, zm, zp, zn;
  logic [LEN_W-1:0]     ext;
  logic [SC_W-1:0]      scale;
  logic [AD_W+31:0]     plo [3];
  logic [AD_W+31:0]     phi [3];
  logic [NUM_W-1:0]     num [3];
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     rest_ext;

  assign len      = sroot[SQRT_STEPS];
  assign rest_ext = LEN_W'(rest_length);

  // division pipeline, index 0 loaded by the overflow stage
  logic             dv   [0:DIV_STEPS];
  logic [2:0]       ddp  [0:DIV_STEPS];
  logic             dz   [0:DIV_STEPS];
  logic [LEN_W-1:0] dlen [0:DIV_STEPS];
  logic [2:0]       dovf [0:DIV_STEPS];
  logic [NUM_W-1:0] drem [0:DIV_STEPS][3];
  logic [Q_W-1:0]   dq   [0:DIV_STEPS][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ve    <= 1'b0;
      vm    <= 1'b0;
      vp    <= 1'b0;
      vn    <= 1'b0;
      dv[0] <= 1'b0;
    end else if (adv) begin
      ve    <= sv[SQRT_STEPS];
      vm    <= ve;
      vp    <= vm;
      vn    <= vp;
      dv[0] <= vn;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ce  <= sc[SQRT_STEPS];
      le  <= len;
      ze  <= (len == '0);
      ext <= (len >= rest_ext) ? len - rest_ext : rest_ext - len;

      cm    <= ce;
      lm    <= le;
      zm    <= ze;
      scale <= ext * spring_constant;

      cp <= cm;
      lp <= lm;
      zp <= zm;
      for (int i = 0; i < 3; i++) begin
        plo[i] <= cm.ad[i] * scale[31:0];
        phi[i] <= cm.ad[i] * scale[63:32];
      end

      cn <= cp;
      ln <= lp;
      zn <= zp;
      for (int i = 0; i < 3; i++) num[i] <= NUM_W'(plo[i]) + (NUM_W'(phi[i]) << 32);

      ddp[0]  <= cn.dpos;
      dz[0]   <= zn;
      dlen[0] <= ln;
      for (int i = 0; i < 3; i++) begin
        // quotient of 2^32 or more always clamps
        dovf[0][i] <= num[i] >= (NUM_W'(ln) << (FRAC_BITS + Q_W));
        drem[0][i] <= num[i];
        dq[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    logic [NUM_W-1:0] dsub;
    assign dsub = NUM_W'(dlen[k]) << (FRAC_BITS + B);

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (adv) dv[k+1] <= dv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ddp[k+1]  <= ddp[k];
        dz[k+1]   <= dz[k];
        dlen[k+1] <= dlen[k];
        dovf[k+1] <= dovf[k];
        for (int i = 0; i < 3; i++) begin
          if (drem[k][i] >= dsub) begin
            drem[k+1][i] <= drem[k][i] - dsub;
            dq[k+1][i]   <= dq[k][i] | (Q_W'(1) << B);
          end else begin
            drem[k+1][i] <= drem[k][i];
            dq[k+1][i]   <= dq[k][i];
          end
        end
      end
    end
  end

  // clamp, sign and output register
  logic [Q_W-1:0]  lim   [3];
  logic [Q_W-1:0]  mag   [3];
  logic [2:0]      clamp;
  logic [Q_W-1:0]  fval  [3];
  sfu_pkg::result_t res_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i]   = ddp[DIV_STEPS][i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      clamp[i] = dovf[DIV_STEPS][i] || (dq[DIV_STEPS][i] > lim[i]);
      mag[i]   = clamp[i] ? lim[i] : dq[DIV_STEPS][i];
      fval[i]  = ddp[DIV_STEPS][i] ? Q_W'(-mag[i]) : mag[i];
    end
    if (dz[DIV_STEPS]) begin
      res_next = '0;
    end else begin
      res_next.force_x   = fval[0];
      res_next.force_y   = fval[1];
      res_next.force_z   = fval[2];
      res_next.saturated = |clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (adv) result_valid <= dv[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) result <= res_next;
  end

  // floor square root leaves a remainder no larger than twice the root
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sv[SQRT_STEPS] |-> (srem[SQRT_STEPS] <= (RT_W'(sroot[SQRT_STEPS]) << 1)))
    else $error("square root remainder out of range");

  // a divide that did not overflow ends with a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv[DIV_STEPS] && !dz[DIV_STEPS] && (dovf[DIV_STEPS] == 3'b000)) |->
      ((drem[DIV_STEPS][0] < (NUM_W'(dlen[DIV_STEPS]) << FRAC_BITS)) &&
       (drem[DIV_STEPS][1] < (NUM_W'(dlen[DIV_STEPS]) << FRAC_BITS)) &&
       (drem[DIV_STEPS][2] < (NUM_W'(dlen[DIV_STEPS]) << FRAC_BITS))))
    else $error("divider remainder out of range");

  // a clamped result can never be all zero
  a_sat_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturated) |->
      ((result.force_x != '0) || (result.force_y != '0) || (result.force_z != '0)))
    else $error("saturated flag on zero force");

endmodule

// ===== test/tb_spring_force_unit.sv =====
module tb_spring_force_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int PIPE_DRAIN = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_stall;
  sfu_pkg::pair_t pair = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  sfu_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic cfg_index = sfu_pkg::CFG_REST;
  logic [30:0] cfg_data = '0;

  spring_force_unit dut (.*);

  always #5 clk = ~clk;

  logic [30:0] rest_len = 31'd65536;
  logic [30:0] stiffness = 31'd65536;
  sfu_pkg::result_t force_queue[$];
  int fails = 0;
  int pairs_sent = 0;
  int forces_seen = 0;
  int sat_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_pending = 1'b0;
  int quiet_cycles = 0;

  function automatic sfu_pkg::result_t spring_force(sfu_pkg::pair_t p);
    logic signed [32:0] d[3];
    logic [32:0] ad[3];
    logic [127:0] sq, c2, num, dv, q, limit;
    logic [34:0] len, cand, ext;
    logic [31:0] m;
    logic signed [31:0] pos[3], oth[3], f[3];
    sfu_pkg::result_t r;
    pos = '{p.particle_x, p.particle_y, p.particle_z};
    oth = '{p.other_x, p.other_y, p.other_z};
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 33'(pos[i]) - 33'(oth[i]);
      ad[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
      sq += 128'(ad[i]) * 128'(ad[i]);
    end
    len = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = len | (35'd1 << b);
      c2 = 128'(cand) * 128'(cand);
      if (c2 <= sq) len = cand;
    end
    r = '0;
    if (len == 0) return r;
    ext = len >= 35'(rest_len) ? len - 35'(rest_len) : 35'(rest_len) - len;
    dv = 128'(len) << FRAC;
    for (int i = 0; i < 3; i++) begin
      num = 128'(ad[i]) * 128'(ext) * 128'(stiffness);
      q = num / dv;
      limit = d[i] > 0 ? 128'h80000000 : 128'h7FFFFFFF;
      if (q > limit) begin
        m = limit[31:0];
        r.saturated = 1'b1;
      end else begin
        m = q[31:0];
      end
      f[i] = d[i] > 0 ? 32'(0 - m) : m;
    end
    r.force_x = f[0];
    r.force_y = f[1];
    r.force_z = f[2];
    return r;
  endfunction

  // receiver: random stall, or a long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    sfu_pkg::result_t exp_force;
    if (!rst && result_valid && !result_stall) begin
      forces_seen++;
      if (result.saturated) sat_seen++;
      if (force_queue.size() == 0) begin
        $error("unexpected result transfer: %p", result);
        fails++;
      end else begin
        exp_force = force_queue.pop_front();
        if (result.force_x !== exp_force.force_x) begin
          $error("force_x expected %h actual %h", exp_force.force_x, result.force_x);
          fails++;
        end
        if (result.force_y !== exp_force.force_y) begin
          $error("force_y expected %h actual %h", exp_force.force_y, result.force_y);
          fails++;
        end
        if (result.force_z !== exp_force.force_z) begin
          $error("force_z expected %h actual %h", exp_force.force_z, result.force_z);
          fails++;
        end
        if (result.saturated !== exp_force.saturated) begin
          $error("saturated expected %b actual %b", exp_force.saturated, result.saturated);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((pair_valid && !pair_stall) || (result_valid && !result_stall) || rst || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", force_queue.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_pair(sfu_pkg::pair_t p, bit typed, sfu_pkg::result_t typed_force);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      pair_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pair <= p;
    pair_valid <= 1'b1;
    @(posedge clk);
    while (pair_stall) @(posedge clk);
    force_queue = {force_queue, (typed ? typed_force : spring_force(p))};
    pairs_sent++;
  endtask

  task automatic drain_pipe();
    pair_valid <= 1'b0;
    while (force_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sfu_pkg::CFG_REST) rest_len = value;
    else stiffness = value;
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(3))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic sfu_pkg::pair_t random_pair();
    sfu_pkg::pair_t p;
    logic signed [31:0] off;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2: ;
      3, 4, 5, 6: begin
        // short springs around a random anchor
        p.other_x = $signed($urandom) >>> $urandom_range(16);
        p.other_y = $signed($urandom) >>> $urandom_range(16);
        p.other_z = $signed($urandom) >>> $urandom_range(16);
        p.particle_x = p.other_x + ($signed($urandom) >>> (12 + $urandom_range(16)));
        p.particle_y = p.other_y + ($signed($urandom) >>> (12 + $urandom_range(16)));
        p.particle_z = p.other_z + ($signed($urandom) >>> (12 + $urandom_range(16)));
      end
      7: begin
        p.particle_x = p.other_x;
        p.particle_y = p.other_y;
        p.particle_z = p.other_z;
      end
      8: p = {pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord()};
      default: begin
        // near rest length along one axis
        off = $signed({1'b0, rest_len}) + $signed(32'($urandom_range(64))) - 32'sd32;
        p.particle_y = p.other_y;
        p.particle_z = p.other_z;
        p.particle_x = $urandom_range(1) ? p.other_x + off : p.other_x - off;
      end
    endcase
    return p;
  endfunction

  typedef struct {
    sfu_pkg::pair_t p;
    bit typed;
    sfu_pkg::result_t f;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    logic [30:0] cfg_rest[6], cfg_k[6];
    rows = {rows, stim_row_t'{'0, 1'b1, '0}};
    rows = {rows, stim_row_t'{{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b1, '0}};
    rows = {rows, stim_row_t'{{2 * ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
                              '{-ONE, 32'sd0, 32'sd0, 1'b0}}};
    // compressed spring still pulls toward the other end
    rows = {rows, stim_row_t'{{ONE / 2, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
                              '{-(ONE / 2), 32'sd0, 32'sd0, 1'b0}}};
    rows = {rows, stim_row_t'{{32'sd0, -2 * ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
                              '{32'sd0, ONE, 32'sd0, 1'b0}}};
    rows = {rows, stim_row_t'{{32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, ONE}, 1'b1, '0}};
    rows = {rows, stim_row_t'{{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN}, 1'b0, '0}};
    rows = {rows, stim_row_t'{{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX}, 1'b0, '0}};
    rows = {rows, stim_row_t'{{Q_MAX, Q_MIN, 32'sd0, Q_MIN, Q_MAX, -32'sd1}, 1'b0, '0}};
    rows = {rows, stim_row_t'{{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0}};
    rows = {rows, stim_row_t'{{-32'sd1, -32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0}, 1'b0,
                              '0}};
    rows = {rows, stim_row_t'{{3 * ONE, 4 * ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0}};
    rows = {rows, stim_row_t'{{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F,
                               32'shAAAAAAAA, 32'sh55555555, 32'shF0F0F0F0}, 1'b0, '0}};

    cfg_rest = '{31'd0, 31'h7FFFFFFF, 31'd65536, 31'h7FFFFFFF, 31'd0, 31'd0};
    cfg_k = '{31'd65536, 31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd0, 31'd0};
    cfg_rest[4] = 31'($urandom);
    cfg_k[4] = 31'($urandom);
    cfg_rest[5] = 31'($urandom_range(1 << 20));
    cfg_k[5] = 31'($urandom_range(1 << 19));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].f);
    drain_pipe();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sfu_pkg::CFG_REST, cfg_rest[ph]);
      write_reg(sfu_pkg::CFG_SPRING, cfg_k[ph]);
      for (int n = 0; n < 265; n++) begin
        if (n % 60 == 0) begin
          case ((n / 60 + ph) % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 80; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 80; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
          endcase
        end
        if (ph == 2 && n == 20) hold_pending = 1'b1;
        send_pair(random_pair(), 1'b0, '0);
      end
      drain_pipe();
    end

    $display("%0d pairs sent, %0d forces checked (%0d saturated) over 7 register settings",
             pairs_sent, forces_seen, sat_seen);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
